// ----- hdl/lfu_pkg.sv -----
// Shared types and constants for the LFU cache with LRU tie-break.
package lfu_pkg;

  localparam int DATA_W              = 32;
  localparam int CAP_W               = 5;
  localparam int DEFAULT_MAX_ENTRIES = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] COUNT_ONE  = 32'd1;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } st_t;

  // Sequencer strobes to the entry unit.
  typedef struct packed {
    logic start;   // latch request, clear scan trackers
    logic scan;    // read data valid during the search sweep
    logic decide;  // settle target, threshold and result
    logic update;  // read data valid during the write-back sweep
  } ctl_t;

  // Decision flags back to the sequencer.
  typedef struct packed {
    logic act;     // request needs a write-back sweep
    logic ins;     // new key is loaded
    logic grow;    // new key is loaded without an eviction
  } sts_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } res_t;

endpackage

// ----- hdl/lfu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lfu_entry_unit.sv -----
// Shared per-entry compare and update unit: key match, victim search, rank rewrite.
module lfu_entry_unit #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lfu_pkg::ctl_t                          ctl,
  input  logic                                   full,
  input  logic                                   req_cmd,
  input  logic [lfu_pkg::DATA_W-1:0]             req_key,
  input  logic [lfu_pkg::DATA_W-1:0]             req_val,
  input  logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_idx,
  input  logic                                   rd_vbit,
  input  logic [3*lfu_pkg::DATA_W+(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] rdata,
  output logic                                   we,
  output logic [3*lfu_pkg::DATA_W+(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] wdata,
  output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] tgt_idx,
  output lfu_pkg::sts_t                          sts,
  output lfu_pkg::res_t                          res
);

  import lfu_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Request
  logic              cmd_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] val_r;

  // Entry word fields
  logic [DATA_W-1:0] e_key, e_val, e_cnt;
  logic [IDX_W-1:0]  e_rank;

  // Search trackers
  logic              found_r;
  logic [IDX_W-1:0]  found_idx_r;
  logic [IDX_W-1:0]  found_rank_r;
  logic [DATA_W-1:0] found_val_r;
  logic              best_vld_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [IDX_W-1:0]  best_rank_r;
  logic [DATA_W-1:0] best_cnt_r;
  logic [DATA_W-1:0] best_key_r;
  logic              free_vld_r;
  logic [IDX_W-1:0]  free_idx_r;

  // Decision
  logic [IDX_W-1:0]  tgt_idx_r;
  logic [IDX_W-1:0]  thr_r;
  logic              ins_r;
  logic              grow_r;
  res_t              res_r;

  logic match, better, first_free;
  logic is_put, evict_c;
  logic [DATA_W-1:0] cnt_inc;
  logic              rank_bump;

  assign e_key  = rdata[3*DATA_W+IDX_W-1 -: DATA_W];
  assign e_val  = rdata[2*DATA_W+IDX_W-1 -: DATA_W];
  assign e_cnt  = rdata[DATA_W+IDX_W-1 -: DATA_W];
  assign e_rank = rdata[IDX_W-1:0];

  assign match = rd_vbit && (e_key == key_r) && !found_r;
  assign better = rd_vbit && (!best_vld_r || (e_cnt < best_cnt_r) ||
                  ((e_cnt == best_cnt_r) && (e_rank > best_rank_r)));
  assign first_free = !rd_vbit && !free_vld_r;

  assign is_put  = (cmd_r == CMD_PUT);
  assign evict_c = !found_r && is_put && full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      best_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
      ins_r      <= 1'b0;
      grow_r     <= 1'b0;
    end else if (ctl.start) begin
      found_r    <= 1'b0;
      best_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
    end else if (ctl.scan) begin
      if (match) begin
        found_r <= 1'b1;
      end
      if (better) begin
        best_vld_r <= 1'b1;
      end
      if (first_free) begin
        free_vld_r <= 1'b1;
      end
    end else if (ctl.decide) begin
      ins_r  <= !found_r && is_put;
      grow_r <= !found_r && is_put && !full;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r <= req_cmd;
      key_r <= req_key;
      val_r <= req_val;
    end
    if (ctl.scan) begin
      if (match) begin
        found_idx_r  <= rd_idx;
        found_rank_r <= e_rank;
        found_val_r  <= e_val;
      end
      if (better) begin
        best_idx_r  <= rd_idx;
        best_rank_r <= e_rank;
        best_cnt_r  <= e_cnt;
        best_key_r  <= e_key;
      end
      if (first_free) begin
        free_idx_r <= rd_idx;
      end
    end
    if (ctl.decide) begin
      tgt_idx_r <= found_r ? found_idx_r : (full ? best_idx_r : free_idx_r);
      thr_r     <= found_r ? found_rank_r : best_rank_r;
      res_r.hit <= found_r;
      res_r.read_value  <= (found_r && !is_put) ? found_val_r : MISS_VALUE;
      res_r.evicted     <= evict_c;
      res_r.evicted_key <= evict_c ? best_key_r : '0;
    end
  end

  // Write-back: target gets the fresh word, other live entries age.
  assign cnt_inc   = (e_cnt == COUNT_MAX) ? e_cnt : e_cnt + COUNT_ONE;
  assign rank_bump = grow_r || (e_rank < thr_r);

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    if (ctl.update) begin
      if (rd_idx == tgt_idx_r) begin
        we = 1'b1;
        if (ins_r) begin
          wdata = {key_r, val_r, COUNT_ONE, {IDX_W{1'b0}}};
        end else begin
          wdata = {e_key, (is_put ? val_r : e_val), cnt_inc, {IDX_W{1'b0}}};
        end
      end else if (rd_vbit) begin
        we = 1'b1;
        wdata = {e_key, e_val, e_cnt, e_rank + IDX_W'(rank_bump)};
      end
    end
  end

  assign tgt_idx  = tgt_idx_r;
  assign sts.act  = found_r || is_put;
  assign sts.ins  = ins_r;
  assign sts.grow = grow_r;
  assign res      = res_r;

endmodule

// ----- hdl/lfu_cache_with_lru_tiebreak.sv -----
// Top level: LFU cache with LRU tie-break, sequencer and entry bookkeeping.
// A request transfers when start is high and busy is low. The block then
// sweeps all MAX_ENTRIES slots of one entry RAM through a single compare
// unit to find the key, the eviction victim (lowest use count, oldest
// among equals) and the first free slot, passes through a decide state, and
// sweeps the RAM a second time to rewrite the touched entry and the
// recency ranks of the others. The result shows on the out_ ports for
// exactly one cycle with out_valid high; the receiver cannot stall it, so
// sample it then. A get that misses skips the second sweep. Busy drops in
// the cycle after the result, and the block takes no new request until
// then. MAX_ENTRIES defaults to 16. Slot valid bits live in flops and
// clear at reset, so no clearing pass is needed; the RAM holds garbage
// until written and is only trusted where a valid bit is set. The capacity
// register takes a write at any cycle with cfg_valid high; write it only
// while idle. Zero acts as one and values above MAX_ENTRIES act as
// MAX_ENTRIES. Lowering it below the live entry count keeps the store, and
// each later new-key put evicts one entry first.
module lfu_cache_with_lru_tiebreak #(
  parameter int MAX_ENTRIES = lfu_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic signed [lfu_pkg::DATA_W-1:0]  in_key,
  input  logic signed [lfu_pkg::DATA_W-1:0]  in_value,
  // Result channel
  output logic                               out_valid,
  output logic                               out_hit,
  output logic signed [lfu_pkg::DATA_W-1:0]  out_read_value,
  output logic                               out_evicted,
  output logic signed [lfu_pkg::DATA_W-1:0]  out_evicted_key,
  // Capacity register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]          cfg_data
);

  import lfu_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WORD_W = 3 * DATA_W + IDX_W;

  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  ctl_t             ctl;

  logic [CAP_W-1:0]       cap_r;
  logic [CNT_W-1:0]       in_use_r;
  logic [MAX_ENTRIES-1:0] valid_r;

  logic [31:0] cap_ext, cap_eff, in_use_ext;
  logic        full;

  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [IDX_W-1:0]  tgt_idx;
  sts_t              sts;
  res_t              res;
  logic              sweep_last;

  // Capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Clamp capacity into 1..MAX_ENTRIES
  always_comb begin
    cap_ext = 32'(cap_r);
    cap_eff = (cap_ext == 32'd0) ? 32'd1 : cap_ext;
    if (cap_eff > 32'(MAX_ENTRIES)) begin
      cap_eff = 32'(MAX_ENTRIES);
    end
    in_use_ext = 32'(in_use_r);
    full       = (in_use_ext >= cap_eff);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
  end

  // Last read of a sweep lands this cycle
  assign sweep_last = (cnt_r == CNT_W'(MAX_ENTRIES)) && rd_vld_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    ctl        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.start  = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN, ST_UPDATE: begin
        ctl.scan   = (state_r == ST_SCAN) && rd_vld_r;
        ctl.update = (state_r == ST_UPDATE) && rd_vld_r;
        if (cnt_r != CNT_W'(MAX_ENTRIES)) begin
          // issue the next read of the sweep
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
        if (sweep_last) begin
          state_nxt = (state_r == ST_SCAN) ? ST_DECIDE : ST_DONE;
        end
      end
      ST_DECIDE: begin
        ctl.decide = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = sts.act ? ST_UPDATE : ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // Valid bits and live count: commit once the write-back is finished
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      in_use_r <= '0;
    end else if (state_r == ST_DONE) begin
      if (sts.ins) begin
        valid_r[tgt_idx] <= 1'b1;
      end
      if (sts.grow) begin
        in_use_r <= in_use_r + CNT_W'(1);
      end
    end
  end

  lfu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_idx_r),
    .wdata (ram_wdata),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  lfu_entry_unit #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_entry_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .full    (full),
    .req_cmd (in_command),
    .req_key (in_key),
    .req_val (in_value),
    .rd_idx  (rd_idx_r),
    .rd_vbit (valid_r[rd_idx_r]),
    .rdata   (ram_rdata),
    .we      (ram_we),
    .wdata   (ram_wdata),
    .tgt_idx (tgt_idx),
    .sts     (sts),
    .res     (res)
  );

  // Result strobe and payload
  assign out_valid       = (state_r == ST_DONE);
  assign out_hit         = res.hit;
  assign out_read_value  = res.read_value;
  assign out_evicted     = res.evicted;
  assign out_evicted_key = res.evicted_key;

`ifndef ASSERT_OFF
  // Live count tracks the valid bits
  a_in_use_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(in_use_r))
    else $error("entry count disagrees with valid bits");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit reported together with eviction");

  // No eviction means a zero evicted key
  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_key == '0))
    else $error("evicted key set without eviction");

  // A transfer starts the sweep
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == ST_SCAN))
    else $error("request transfer did not start a sweep");
`endif

endmodule
